// File: src/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants for the page-table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int PAGE_OFFSET_BITS = 12;
  localparam int MAX_LEVELS       = 4;

  localparam logic [1:0] OP_START     = 2'd0;
  localparam logic [1:0] OP_PTE_DATA  = 2'd1;
  localparam logic [1:0] OP_WRITE_ACK = 2'd2;

  localparam logic [2:0] KIND_READ    = 3'd0;
  localparam logic [2:0] KIND_WRITE   = 3'd1;
  localparam logic [2:0] KIND_DONE    = 3'd2;
  localparam logic [2:0] KIND_FAULT   = 3'd3;
  localparam logic [2:0] KIND_IGNORED = 3'd4;

  localparam logic [2:0] CFG_ROOT   = 3'd0;
  localparam logic [2:0] CFG_WIDE   = 3'd1;
  localparam logic [2:0] CFG_STATUS = 3'd2;
  localparam logic [2:0] CFG_UPDATE = 3'd3;
  localparam logic [2:0] CFG_BASE   = 3'd4;
  localparam logic [2:0] CFG_SIZE   = 3'd5;

  localparam logic [1:0] ACC_LOAD  = 2'd0;
  localparam logic [1:0] ACC_STORE = 2'd1;
  localparam logic [1:0] ACC_FETCH = 2'd2;
  localparam logic [1:0] ACC_OTHER = 2'd3;

  localparam logic [1:0] PRIV_USER    = 2'd0;
  localparam logic [1:0] PRIV_SUPER   = 2'd1;
  localparam logic [1:0] PRIV_MACHINE = 2'd3;

  localparam logic [3:0] MODE_BARE = 4'd0;
  localparam logic [3:0] MODE_SV32 = 4'd1;
  localparam logic [3:0] MODE_SV39 = 4'd8;
  localparam logic [3:0] MODE_SV48 = 4'd9;

  localparam logic [2:0] RWX_POINTER       = 3'd0;
  localparam logic [2:0] RWX_WRITE_ONLY    = 3'd2;
  localparam logic [2:0] RWX_WRITE_EXECUTE = 3'd6;

  localparam logic [7:0] PTE_A = 8'h40;
  localparam logic [7:0] PTE_D = 8'h80;

  typedef enum logic [1:0] {
    CLS_START,
    CLS_DATA,
    CLS_ACK,
    CLS_IGNORE
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [63:0] va;
    logic [1:0]  access;
    logic [1:0]  priv;
    logic [63:0] pte;
  } item_t;

  typedef struct packed {
    logic [63:0] root;
    logic        wide;
    logic        mxr;
    logic        sum;
    logic        upd;
    logic [63:0] base;
    logic [63:0] size;
  } cfg_t;

endpackage

// File: src/ptw_front.sv
// ----------------------------------------------------------------------------
// ptw_front
// Classifies incoming items and normalises their fields for the queue.
// ----------------------------------------------------------------------------
module ptw_front (
  input  logic [1:0]     in_opcode,
  input  logic [63:0]    in_virt_addr,
  input  logic [1:0]     in_access_kind,
  input  logic [1:0]     in_privilege,
  input  logic [63:0]    in_pte_data,
  input  logic           wide,
  output ptw_pkg::item_t item
);

  always_comb begin
    unique case (in_opcode)
      ptw_pkg::OP_START:     item.cls = ptw_pkg::CLS_START;
      ptw_pkg::OP_PTE_DATA:  item.cls = ptw_pkg::CLS_DATA;
      ptw_pkg::OP_WRITE_ACK: item.cls = ptw_pkg::CLS_ACK;
      default:               item.cls = ptw_pkg::CLS_IGNORE;
    endcase
    item.va     = wide ? in_virt_addr : {32'd0, in_virt_addr[31:0]};
    item.access = (in_access_kind == ptw_pkg::ACC_OTHER) ? ptw_pkg::ACC_LOAD
                                                         : in_access_kind;
    item.priv   = in_privilege;
    item.pte    = in_pte_data;
  end

endmodule

// File: src/ptw_queue.sv
// ----------------------------------------------------------------------------
// ptw_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module ptw_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ptw_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output ptw_pkg::item_t head_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ptw_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: src/ptw_back.sv
// ----------------------------------------------------------------------------
// ptw_back
// Walk engine: one queued item per cycle unless stalled; registers its result.
// ----------------------------------------------------------------------------
module ptw_back (
  input  logic           clk,
  input  logic           rst_n,
  input  ptw_pkg::cfg_t  cfg,
  input  logic           head_valid,
  input  ptw_pkg::item_t head_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     out_result_kind,
  output logic [63:0]    out_address,
  output logic           out_pte_is_wide,
  output logic [7:0]     out_update_mask,
  output logic [2:0]     out_fault_cause
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READ,
    PH_WRITE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  level_r, level_nxt;
  logic [63:0] vaddr_r, vaddr_nxt;
  logic [1:0]  access_r, access_nxt;
  logic [1:0]  priv_r, priv_nxt;
  logic [63:0] eaddr_r, eaddr_nxt;
  logic        ewide_r, ewide_nxt;
  logic [63:0] pphys_r, pphys_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic        owide_r, owide_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [2:0]  cause_r, cause_nxt;

  function automatic logic [5:0] level_bits(input logic [1:0] lvl, input logic w);
    logic [5:0] n;
    unique case (lvl)
      2'd0:    n = 6'd0;
      2'd1:    n = w ? 6'd9  : 6'd10;
      2'd2:    n = w ? 6'd18 : 6'd20;
      default: n = w ? 6'd27 : 6'd30;
    endcase
    return n;
  endfunction

  assign pop             = head_valid && (!out_valid_r || !out_stall);
  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_address     = addr_r;
  assign out_pte_is_wide = owide_r;
  assign out_update_mask = mask_r;
  assign out_fault_cause = cause_r;

  always_comb begin
    logic [63:0] root, va, pte, ppn, req_table, req_va, vpn_raw, low_mask, om, phys;
    logic [63:0] req_addr, off;
    logic [64:0] diff, span;
    logic [3:0]  mode;
    logic [1:0]  req_level, start_level, acc;
    logic [11:0] vpn_off;
    logic [6:0]  shift;
    logic [2:0]  rwx, perm;
    logic [7:0]  ad_mask;
    logic        wide, req_wide, in_ram, start_pass, start_fault, start_ok, allowed, user;

    phase_nxt  = phase_r;
    level_nxt  = level_r;
    vaddr_nxt  = vaddr_r;
    access_nxt = access_r;
    priv_nxt   = priv_r;
    eaddr_nxt  = eaddr_r;
    ewide_nxt  = ewide_r;
    pphys_nxt  = pphys_r;
    kind_nxt   = ptw_pkg::KIND_IGNORED;
    addr_nxt   = '0;
    owide_nxt  = 1'b0;
    mask_nxt   = '0;
    cause_nxt  = '0;

    wide  = cfg.wide;
    root  = wide ? cfg.root : {32'd0, cfg.root[31:0]};
    va    = head_item.va;
    mode  = wide ? root[63:60] : {3'd0, root[31]};
    start_pass  = (head_item.priv == ptw_pkg::PRIV_MACHINE) || (mode == ptw_pkg::MODE_BARE);
    start_fault = 1'b0;
    start_level = 2'd0;
    ppn         = '0;
    if (!wide && mode == ptw_pkg::MODE_SV32) begin
      start_level = 2'd1;
      ppn = {42'd0, root[21:0]};
    end else if (wide && mode == ptw_pkg::MODE_SV39) begin
      start_fault = !((&va[63:38]) || (va[63:38] == '0));
      start_level = 2'd2;
      ppn = {20'd0, root[43:0]};
    end else if (wide && mode == ptw_pkg::MODE_SV48) begin
      start_fault = !((&va[63:47]) || (va[63:47] == '0)) || (ptw_pkg::MAX_LEVELS < 4);
      start_level = 2'd3;
      ppn = {20'd0, root[43:0]};
    end else begin
      start_fault = 1'b1;
    end
    if (32'(start_level) + 32'd1 > ptw_pkg::MAX_LEVELS) begin
      start_fault = 1'b1;
    end
    start_ok = !start_pass && !start_fault;

    pte = ewide_r ? head_item.pte : {32'd0, head_item.pte[31:0]};
    rwx = pte[3:1];

    if (head_item.cls == ptw_pkg::CLS_START) begin
      req_va    = va;
      req_level = start_level;
      req_wide  = wide;
      req_table = ppn << ptw_pkg::PAGE_OFFSET_BITS;
    end else begin
      req_va    = vaddr_r;
      req_level = level_r - 2'd1;
      req_wide  = ewide_r;
      req_table = (pte >> 10) << ptw_pkg::PAGE_OFFSET_BITS;
    end
    vpn_raw  = req_va >> (7'd12 + 7'(level_bits(req_level, req_wide)));
    vpn_off  = req_wide ? {vpn_raw[8:0], 3'd0} : {vpn_raw[9:0], 2'd0};
    req_addr = {req_table[63:12], vpn_off};
    diff     = {1'b0, req_addr} - {1'b0, cfg.base};
    off      = diff[63:0];
    span     = {1'b0, off} + (req_wide ? 65'd8 : 65'd4);
    in_ram   = !diff[64] && (span <= {1'b0, cfg.size});

    ppn      = pte >> 10;
    user     = pte[4];
    perm     = {rwx[2], rwx[1], rwx[0] || (cfg.mxr && rwx[2])};
    allowed  = perm[access_r] && (rwx != ptw_pkg::RWX_WRITE_ONLY) &&
               (rwx != ptw_pkg::RWX_WRITE_EXECUTE);
    if (priv_r == ptw_pkg::PRIV_SUPER && user &&
        (access_r == ptw_pkg::ACC_FETCH || !cfg.sum)) begin
      allowed = 1'b0;
    end
    if (priv_r == ptw_pkg::PRIV_USER && !user) begin
      allowed = 1'b0;
    end
    low_mask = (64'd1 << level_bits(level_r, ewide_r)) - 64'd1;
    shift    = 7'd12 + 7'(level_bits(level_r, ewide_r));
    om       = (64'd1 << shift) - 64'd1;
    phys     = (vaddr_r & om) | ((ppn << ptw_pkg::PAGE_OFFSET_BITS) & ~om);
    ad_mask  = (ptw_pkg::PTE_A | ((access_r == ptw_pkg::ACC_STORE) ? ptw_pkg::PTE_D : 8'd0))
               & ~pte[7:0];

    acc = access_r;
    unique case (head_item.cls)
      ptw_pkg::CLS_START: begin
        acc        = head_item.access;
        vaddr_nxt  = va;
        access_nxt = head_item.access;
        priv_nxt   = head_item.priv;
        ewide_nxt  = wide;
        phase_nxt  = PH_IDLE;
        if (start_pass) begin
          kind_nxt = ptw_pkg::KIND_DONE;
          addr_nxt = va;
        end else if (start_fault) begin
          kind_nxt  = ptw_pkg::KIND_FAULT;
          cause_nxt = {1'b0, acc};
        end
        if (start_ok) begin
          level_nxt = start_level;
        end
      end
      ptw_pkg::CLS_DATA: begin
        if (phase_r == PH_READ) begin
          phase_nxt = PH_IDLE;
          kind_nxt  = ptw_pkg::KIND_FAULT;
          cause_nxt = {1'b0, acc};
          if (!pte[0] || (ewide_r && pte[63:54] != '0)) begin
            kind_nxt = ptw_pkg::KIND_FAULT;
          end else if (rwx == ptw_pkg::RWX_POINTER) begin
            if (!pte[7] && level_r != 2'd0) begin
              level_nxt = level_r - 2'd1;
            end
          end else if (allowed && (ppn & low_mask) == '0) begin
            cause_nxt = '0;
            if (cfg.upd && ad_mask != '0) begin
              pphys_nxt = phys;
              phase_nxt = PH_WRITE;
              kind_nxt  = ptw_pkg::KIND_WRITE;
              addr_nxt  = eaddr_r;
              owide_nxt = ewide_r;
              mask_nxt  = ad_mask;
            end else begin
              kind_nxt = ptw_pkg::KIND_DONE;
              addr_nxt = phys;
            end
          end
        end
      end
      ptw_pkg::CLS_ACK: begin
        if (phase_r == PH_WRITE) begin
          phase_nxt = PH_IDLE;
          kind_nxt  = ptw_pkg::KIND_DONE;
          addr_nxt  = pphys_r;
        end
      end
      default: begin
      end
    endcase

    if ((head_item.cls == ptw_pkg::CLS_START && start_ok) ||
        (head_item.cls == ptw_pkg::CLS_DATA && phase_r == PH_READ && pte[0] &&
         !(ewide_r && pte[63:54] != '0) && rwx == ptw_pkg::RWX_POINTER && !pte[7] &&
         level_r != 2'd0)) begin
      eaddr_nxt = req_addr;
      cause_nxt = '0;
      if (in_ram) begin
        phase_nxt = PH_READ;
        kind_nxt  = ptw_pkg::KIND_READ;
        addr_nxt  = req_addr;
        owide_nxt = req_wide;
      end else begin
        phase_nxt = PH_IDLE;
        kind_nxt  = ptw_pkg::KIND_FAULT;
        cause_nxt = {1'b0, acc} + 3'd3;
      end
    end

    out_valid_nxt = pop ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      level_r     <= '0;
      vaddr_r     <= '0;
      access_r    <= '0;
      priv_r      <= '0;
      eaddr_r     <= '0;
      ewide_r     <= 1'b0;
      pphys_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r  <= phase_nxt;
        level_r  <= level_nxt;
        vaddr_r  <= vaddr_nxt;
        access_r <= access_nxt;
        priv_r   <= priv_nxt;
        eaddr_r  <= eaddr_nxt;
        ewide_r  <= ewide_nxt;
        pphys_r  <= pphys_nxt;
      end
    end
    if (pop) begin
      kind_r  <= kind_nxt;
      addr_r  <= addr_nxt;
      owide_r <= owide_nxt;
      mask_r  <= mask_nxt;
      cause_r <= cause_nxt;
    end
  end

endmodule

// File: src/page_table_walker_core.sv
// ----------------------------------------------------------------------------
// page_table_walker_core
// RISC-V Sv32/Sv39/Sv48 page-table walker with a decoupled front and back.
// ----------------------------------------------------------------------------
// Every item gives exactly one result item. The walk engine completes one item
// per cycle while the output register is free, so items then stream at one a
// cycle. An accepted item is written into the queue, and the engine pops it
// from there and registers its result in the output register. The input
// stalls only when the queue of QUEUE_DEPTH items is full, and the queue
// drains whenever the output register is free.
module page_table_walker_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_virt_addr,
  input  logic [1:0]  in_access_kind,
  input  logic [1:0]  in_privilege,
  input  logic [63:0] in_pte_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_kind,
  output logic [63:0] out_address,
  output logic        out_pte_is_wide,
  output logic [7:0]  out_update_mask,
  output logic [2:0]  out_fault_cause,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  ptw_pkg::cfg_t  cfg_r;
  ptw_pkg::item_t front_item, head_item;
  logic           q_full, head_valid, pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptw_pkg::CFG_ROOT:   cfg_r.root <= cfg_data;
        ptw_pkg::CFG_WIDE:   cfg_r.wide <= cfg_data[0];
        ptw_pkg::CFG_STATUS: begin
          cfg_r.mxr <= cfg_data[0];
          cfg_r.sum <= cfg_data[1];
        end
        ptw_pkg::CFG_UPDATE: cfg_r.upd  <= cfg_data[0];
        ptw_pkg::CFG_BASE:   cfg_r.base <= cfg_data;
        ptw_pkg::CFG_SIZE:   cfg_r.size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ptw_front u_front (
    .in_opcode      (in_opcode),
    .in_virt_addr   (in_virt_addr),
    .in_access_kind (in_access_kind),
    .in_privilege   (in_privilege),
    .in_pte_data    (in_pte_data),
    .wide           (cfg_r.wide),
    .item           (front_item)
  );

  ptw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && !q_full),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ptw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_address     (out_address),
    .out_pte_is_wide (out_pte_is_wide),
    .out_update_mask (out_update_mask),
    .out_fault_cause (out_fault_cause)
  );

endmodule

// File: bench/tb_page_table_walker_core.sv
// ----------------------------------------------------------------------------
// tb_page_table_walker_core
// Self-checking bench for the Sv32/Sv39/Sv48 page-table walker: a directed
// table of items and register writes, then random phases of well-formed walks
// with noise, each result checked against the table or the walk predictor.
// ----------------------------------------------------------------------------
module tb_page_table_walker_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic [1:0] PRIV_TWO    = 2'd2;
  localparam logic [1:0] W_IDLE      = 2'd0;
  localparam logic [1:0] W_READ      = 2'd1;
  localparam logic [1:0] W_WRITE     = 2'd2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] addr;
    logic        wide;
    logic [7:0]  mask;
    logic [2:0]  cause;
  } xlat_res_t;

  typedef struct {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [63:0] data;
    logic [1:0]  op;
    logic [63:0] va;
    logic [1:0]  acc;
    logic [1:0]  priv;
    logic [63:0] pte;
    logic        typed;
    logic [2:0]  kind;
    logic [63:0] addr;
    logic [2:0]  cause;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = ptw_pkg::OP_START;
  logic [63:0] in_virt_addr = '0;
  logic [1:0]  in_access_kind = ptw_pkg::ACC_LOAD;
  logic [1:0]  in_privilege = ptw_pkg::PRIV_USER;
  logic [63:0] in_pte_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_result_kind;
  logic [63:0] out_address;
  logic        out_pte_is_wide;
  logic [7:0]  out_update_mask;
  logic [2:0]  out_fault_cause;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = ptw_pkg::CFG_ROOT;
  logic [63:0] cfg_data = '0;

  page_table_walker_core u_dut (.*);

  always #6 clk = ~clk;

  // Register copies and walk state of the predictor.
  logic [63:0] m_root, m_base, m_size;
  logic        m_wide, m_mxr, m_sum, m_upd;
  logic [1:0]  w_phase, w_level, w_acc, w_priv;
  logic [63:0] w_va, w_entry, w_phys;
  logic        w_ewide;
  logic [7:0]  w_mask;

  xlat_res_t pending_results[$];
  int mismatches = 0, results_seen = 0, items_sent = 0, walks_done = 0, faults_seen = 0;
  int burst_left = 0, max_gap = 4;
  logic hold_go = 1'b0;

  function automatic logic in_window(logic [63:0] a, logic [63:0] sz);
    logic [63:0] off;
    if (a < m_base) return 1'b0;
    off = a - m_base;
    if (off > m_size) return 1'b0;
    return (m_size - off) >= sz;
  endfunction

  function automatic xlat_res_t walk_fault(logic acc_fault);
    xlat_res_t r;
    w_phase = W_IDLE;
    r = '{ptw_pkg::KIND_FAULT, 64'd0, 1'b0, 8'd0,
          {1'b0, w_acc} + (acc_fault ? 3'd3 : 3'd0)};
    return r;
  endfunction

  function automatic xlat_res_t fetch_entry(logic [63:0] tbl);
    int vb;
    logic [63:0] vpn, sz;
    xlat_res_t r;
    vb = w_ewide ? 9 : 10;
    sz = w_ewide ? 64'd8 : 64'd4;
    vpn = (w_va >> (ptw_pkg::PAGE_OFFSET_BITS + w_level * vb)) & ((64'd1 << vb) - 64'd1);
    w_entry = tbl + vpn * sz;
    if (!in_window(w_entry, sz)) return walk_fault(1'b1);
    w_phase = W_READ;
    r = '{ptw_pkg::KIND_READ, w_entry, w_ewide, 8'd0, 3'd0};
    return r;
  endfunction

  function automatic xlat_res_t walker_step(logic [1:0] op, logic [63:0] va, logic [1:0] acc,
                                            logic [1:0] priv, logic [63:0] pte_in);
    xlat_res_t r;
    logic [63:0] root, ppn, pte, upper, ones, low_mask, omask;
    logic [3:0] mode;
    logic [2:0] rwx, perm;
    logic [7:0] msk;
    int levels, top, vb, shift;
    logic ok, user;
    r = '{ptw_pkg::KIND_IGNORED, 64'd0, 1'b0, 8'd0, 3'd0};
    if (op == ptw_pkg::OP_START) begin
      root = m_wide ? m_root : {32'd0, m_root[31:0]};
      w_va = m_wide ? va : {32'd0, va[31:0]};
      w_acc = (acc == ptw_pkg::ACC_OTHER) ? ptw_pkg::ACC_LOAD : acc;
      w_priv = priv;
      w_ewide = m_wide;
      w_mask = 8'd0;
      w_phase = W_IDLE;
      mode = m_wide ? root[63:60] : {3'd0, root[31]};
      if (priv == ptw_pkg::PRIV_MACHINE || mode == ptw_pkg::MODE_BARE) begin
        r = '{ptw_pkg::KIND_DONE, w_va, 1'b0, 8'd0, 3'd0};
        return r;
      end
      if (!m_wide && mode == ptw_pkg::MODE_SV32) begin
        levels = 2;
        ppn = {42'd0, root[21:0]};
      end else if (m_wide && (mode == ptw_pkg::MODE_SV39 || mode == ptw_pkg::MODE_SV48)) begin
        top = (mode == ptw_pkg::MODE_SV39) ? 38 : 47;
        upper = w_va >> top;
        ones = (64'd1 << (64 - top)) - 64'd1;
        if (upper != 64'd0 && upper != ones) return walk_fault(1'b0);
        levels = (mode == ptw_pkg::MODE_SV39) ? 3 : 4;
        ppn = {20'd0, root[43:0]};
      end else begin
        return walk_fault(1'b0);
      end
      if (levels > ptw_pkg::MAX_LEVELS) return walk_fault(1'b0);
      w_level = 2'(levels - 1);
      return fetch_entry(ppn << ptw_pkg::PAGE_OFFSET_BITS);
    end
    if (op == ptw_pkg::OP_PTE_DATA && w_phase == W_READ) begin
      vb = w_ewide ? 9 : 10;
      pte = w_ewide ? pte_in : {32'd0, pte_in[31:0]};
      if (!pte[0] || (w_ewide && pte[63:54] != 10'd0)) return walk_fault(1'b0);
      ppn = pte >> 10;
      rwx = pte[3:1];
      if (rwx == ptw_pkg::RWX_POINTER) begin
        if (pte[7] || w_level == 2'd0) return walk_fault(1'b0);
        w_level = w_level - 2'd1;
        return fetch_entry(ppn << ptw_pkg::PAGE_OFFSET_BITS);
      end
      user = pte[4];
      perm = {rwx[2], rwx[1], rwx[0] | (m_mxr & rwx[2])};
      ok = perm[w_acc];
      if (rwx == ptw_pkg::RWX_WRITE_ONLY || rwx == ptw_pkg::RWX_WRITE_EXECUTE) ok = 1'b0;
      if (w_priv == ptw_pkg::PRIV_SUPER && user && (w_acc == ptw_pkg::ACC_FETCH || !m_sum))
        ok = 1'b0;
      if (w_priv == ptw_pkg::PRIV_USER && !user) ok = 1'b0;
      if (!ok) return walk_fault(1'b0);
      low_mask = (w_level == 2'd0) ? 64'd0 : (64'd1 << (w_level * vb)) - 64'd1;
      if ((ppn & low_mask) != 64'd0) return walk_fault(1'b0);
      shift = ptw_pkg::PAGE_OFFSET_BITS + w_level * vb;
      omask = (64'd1 << shift) - 64'd1;
      w_phys = (w_va & omask) | ((ppn << ptw_pkg::PAGE_OFFSET_BITS) & ~omask);
      msk = (ptw_pkg::PTE_A | ((w_acc == ptw_pkg::ACC_STORE) ? ptw_pkg::PTE_D : 8'd0))
            & ~pte[7:0];
      if (m_upd && msk != 8'd0) begin
        w_mask = msk;
        w_phase = W_WRITE;
        r = '{ptw_pkg::KIND_WRITE, w_entry, w_ewide, msk, 3'd0};
        return r;
      end
      w_phase = W_IDLE;
      r = '{ptw_pkg::KIND_DONE, w_phys, 1'b0, 8'd0, 3'd0};
      return r;
    end
    if (op == ptw_pkg::OP_WRITE_ACK && w_phase == W_WRITE) begin
      w_phase = W_IDLE;
      r = '{ptw_pkg::KIND_DONE, w_phys, 1'b0, 8'd0, 3'd0};
    end
    return r;
  endfunction

  task automatic send_item(logic [1:0] op, logic [63:0] va, logic [1:0] acc, logic [1:0] priv,
                           logic [63:0] pte, logic typed, xlat_res_t typed_res);
    xlat_res_t r;
    int gap;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_virt_addr <= va;
    in_access_kind <= acc;
    in_privilege <= priv;
    in_pte_data <= pte;
    do @(posedge clk); while (in_stall);
    r = walker_step(op, va, acc, priv, pte);
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ptw_pkg::CFG_ROOT:   m_root = data;
      ptw_pkg::CFG_WIDE:   m_wide = data[0];
      ptw_pkg::CFG_STATUS: {m_sum, m_mxr} = data[1:0];
      ptw_pkg::CFG_UPDATE: m_upd = data[0];
      ptw_pkg::CFG_BASE:   m_base = data;
      ptw_pkg::CFG_SIZE:   m_size = data;
      default: ;
    endcase
  endtask

  // Receiver: checks results and stalls on a pattern of its own.
  int stall_mode = 0, stall_count = 0, hold_left = 0;
  logic hold_seen = 1'b0;
  always @(posedge clk) begin
    xlat_res_t e;
    if (out_valid && !out_stall) begin
      results_seen++;
      if (out_result_kind == ptw_pkg::KIND_DONE) walks_done++;
      if (out_result_kind == ptw_pkg::KIND_FAULT) faults_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item kind %0d", out_result_kind);
      end else begin
        e = pending_results.pop_front();
        if (out_result_kind !== e.kind || out_address !== e.addr ||
            out_pte_is_wide !== e.wide || out_update_mask !== e.mask ||
            out_fault_cause !== e.cause) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d addr %h wide %0d mask %h cause %0d, got kind %0d addr %h wide %0d mask %h cause %0d",
                     e.kind, e.addr, e.wide, e.mask, e.cause, out_result_kind,
                     out_address, out_pte_is_wide, out_update_mask, out_fault_cause);
        end
      end
    end
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_count == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_count <= $urandom_range(20, 120);
      end else begin
        stall_count <= stall_count - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 75);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_page_table_walker_core NOT OK");
      $finish;
    end
  end

  row_t dir_tab[$];

  initial begin
    row_t rw;
    xlat_res_t tr;
    logic [63:0] va, pte, ppn, tbl_ppn, lowm;
    logic [3:0] mode;
    logic [1:0] acc, priv, op;
    int top, vb, pick;
    m_root = '0; m_base = '0; m_size = '0;
    {m_wide, m_mxr, m_sum, m_upd} = '0;
    w_phase = '0; w_level = '0; w_acc = '0; w_priv = '0;
    w_va = '0; w_entry = '0; w_phys = '0; w_ewide = '0; w_mask = '0;

    dir_tab.push_back('{op: ptw_pkg::OP_START, va: '1, acc: ptw_pkg::ACC_LOAD,
                        priv: ptw_pkg::PRIV_USER, typed: 1'b1,
                        kind: ptw_pkg::KIND_DONE, addr: 64'hFFFF_FFFF, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_PTE_DATA, pte: '1, typed: 1'b1,
                        kind: ptw_pkg::KIND_IGNORED, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_WRITE_ACK, typed: 1'b1,
                        kind: ptw_pkg::KIND_IGNORED, default: '0});
    dir_tab.push_back('{op: OP_RESERVED, va: '1, pte: '1, acc: ptw_pkg::ACC_OTHER,
                        priv: ptw_pkg::PRIV_MACHINE, typed: 1'b1,
                        kind: ptw_pkg::KIND_IGNORED, default: '0});
    dir_tab.push_back('{is_cfg: 1'b1, idx: ptw_pkg::CFG_ROOT, data: 64'h8000_0010,
                        default: '0});
    dir_tab.push_back('{is_cfg: 1'b1, idx: ptw_pkg::CFG_SIZE, data: 64'h1_0000_0000_0000,
                        default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_START, va: 64'h0040_3123, acc: ptw_pkg::ACC_LOAD,
                        priv: ptw_pkg::PRIV_SUPER, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_PTE_DATA, pte: (64'h20 << 10) | 64'h1, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_PTE_DATA, pte: (64'h30 << 10) | 64'h7, default: '0});
    dir_tab.push_back('{is_cfg: 1'b1, idx: ptw_pkg::CFG_UPDATE, data: 64'd1, default: '0});
    dir_tab.push_back('{is_cfg: 1'b1, idx: ptw_pkg::CFG_STATUS, data: 64'd3, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_START, va: 64'h0040_3123, acc: ptw_pkg::ACC_STORE,
                        priv: ptw_pkg::PRIV_SUPER, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_PTE_DATA, pte: (64'h31 << 10) | 64'hC7, typed: 1'b1,
                        kind: ptw_pkg::KIND_FAULT, cause: 3'd1, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_START, va: 64'h0080_0456, acc: ptw_pkg::ACC_FETCH,
                        priv: ptw_pkg::PRIV_USER, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_PTE_DATA, pte: (64'h400 << 10) | 64'h19,
                        default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_WRITE_ACK, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_START, va: 64'h0040_0000, acc: ptw_pkg::ACC_STORE,
                        priv: ptw_pkg::PRIV_USER, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_START, va: 64'h0040_0000, acc: ptw_pkg::ACC_OTHER,
                        priv: ptw_pkg::PRIV_SUPER, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_PTE_DATA, pte: 64'h5, typed: 1'b1,
                        kind: ptw_pkg::KIND_FAULT, cause: 3'd0, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_START, va: 64'h1234_5678, acc: ptw_pkg::ACC_STORE,
                        priv: ptw_pkg::PRIV_MACHINE, typed: 1'b1, kind: ptw_pkg::KIND_DONE,
                        addr: 64'h1234_5678, default: '0});
    dir_tab.push_back('{is_cfg: 1'b1, idx: ptw_pkg::CFG_WIDE, data: 64'd1, default: '0});
    dir_tab.push_back('{is_cfg: 1'b1, idx: ptw_pkg::CFG_ROOT,
                        data: {ptw_pkg::MODE_SV39, 60'h100}, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_START, va: 64'h0000_0040_0000_0000,
                        acc: ptw_pkg::ACC_LOAD, priv: ptw_pkg::PRIV_SUPER, typed: 1'b1,
                        kind: ptw_pkg::KIND_FAULT, cause: 3'd0, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_START, va: '1, acc: ptw_pkg::ACC_LOAD,
                        priv: PRIV_TWO, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_PTE_DATA, pte: 64'h8000_0000_0000_0003, typed: 1'b1,
                        kind: ptw_pkg::KIND_FAULT, cause: 3'd0, default: '0});
    dir_tab.push_back('{is_cfg: 1'b1, idx: ptw_pkg::CFG_ROOT,
                        data: {ptw_pkg::MODE_SV48, 60'h100}, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_START, va: 64'h1000, acc: ptw_pkg::ACC_FETCH,
                        priv: ptw_pkg::PRIV_USER, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_PTE_DATA, pte: 64'h81, typed: 1'b1,
                        kind: ptw_pkg::KIND_FAULT, cause: 3'd2, default: '0});
    dir_tab.push_back('{is_cfg: 1'b1, idx: ptw_pkg::CFG_ROOT, data: {4'd4, 60'h100},
                        default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_START, va: 64'h1000, acc: ptw_pkg::ACC_STORE,
                        priv: ptw_pkg::PRIV_SUPER, typed: 1'b1, kind: ptw_pkg::KIND_FAULT,
                        cause: 3'd1, default: '0});
    dir_tab.push_back('{is_cfg: 1'b1, idx: ptw_pkg::CFG_ROOT,
                        data: {ptw_pkg::MODE_SV39, 60'h100}, default: '0});
    dir_tab.push_back('{is_cfg: 1'b1, idx: ptw_pkg::CFG_SIZE, data: 64'd0, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_START, va: 64'h1000, acc: ptw_pkg::ACC_STORE,
                        priv: ptw_pkg::PRIV_SUPER, typed: 1'b1, kind: ptw_pkg::KIND_FAULT,
                        cause: 3'd4, default: '0});
    dir_tab.push_back('{op: ptw_pkg::OP_PTE_DATA, typed: 1'b1, kind: ptw_pkg::KIND_IGNORED,
                        default: '0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      rw = dir_tab[i];
      if (rw.is_cfg) begin
        settle();
        write_reg(rw.idx, rw.data);
      end else begin
        tr = '{rw.kind, rw.addr, 1'b0, 8'd0, rw.cause};
        send_item(rw.op, rw.va, rw.acc, rw.priv, rw.pte, rw.typed, tr);
      end
    end

    tr = '{ptw_pkg::KIND_IGNORED, 64'd0, 1'b0, 8'd0, 3'd0};
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      max_gap = (ph == 2 || ph == 5) ? 0 : $urandom_range(1, 8);
      case (ph)
        0: begin m_base = 64'd0; m_size = '1; end
        1: begin m_base = 64'h00FF_FFFF_FFF0_0000; m_size = 64'h10_0000; end
        4: begin m_base = 64'h2000_0000; m_size = 64'h3000; end
        default: begin
          m_base = {20'd0, 32'($urandom_range(0, 32'h3F_FFFF)), 12'd0}
                   >> ($urandom_range(0, 1) * 8);
          m_size = 64'h20_0000 + 64'($urandom_range(0, 255));
        end
      endcase
      write_reg(ptw_pkg::CFG_BASE, m_base);
      write_reg(ptw_pkg::CFG_SIZE, m_size);
      write_reg(ptw_pkg::CFG_WIDE, 64'((ph % 3) != 0));
      write_reg(ptw_pkg::CFG_STATUS, 64'(ph % 4));
      write_reg(ptw_pkg::CFG_UPDATE, 64'($urandom_range(0, 1)));
      tbl_ppn = (m_base >> 12) + 64'($urandom_range(0, 63));
      pick = $urandom_range(0, 9);
      if (m_wide) mode = (pick == 0) ? 4'($urandom_range(0, 15))
                                    : ((ph % 2) ? ptw_pkg::MODE_SV48 : ptw_pkg::MODE_SV39);
      else mode = (pick == 0) ? ptw_pkg::MODE_BARE : ptw_pkg::MODE_SV32;
      if (m_wide) write_reg(ptw_pkg::CFG_ROOT, {mode, 16'($urandom), tbl_ppn[43:0]});
      else write_reg(ptw_pkg::CFG_ROOT, {$urandom, mode[0], 9'($urandom), tbl_ppn[21:0]});
      if (ph == 3) hold_go = ~hold_go;
      for (int k = 0; k < 150; k++) begin
        pick = $urandom_range(0, 99);
        acc = 2'($urandom_range(0, 3));
        priv = ($urandom_range(0, 9) == 0) ? ptw_pkg::PRIV_MACHINE
                                           : 2'($urandom_range(0, 2));
        va = {$urandom, $urandom};
        pte = {$urandom, $urandom};
        if (pick < 8) begin
          op = 2'($urandom_range(0, 3));
        end else if (w_phase == W_WRITE && pick < 90) begin
          op = ptw_pkg::OP_WRITE_ACK;
        end else if (w_phase == W_READ && pick < 95) begin
          op = ptw_pkg::OP_PTE_DATA;
          vb = w_ewide ? 9 : 10;
          tbl_ppn = (m_base >> 12) + 64'($urandom_range(0, 63));
          if (w_level != 2'd0 && $urandom_range(0, 99) < 45) begin
            pte = (tbl_ppn << 10) | 64'h1 | (($urandom_range(0, 19) == 0) ? 64'h80 : 64'h0);
          end else begin
            ppn = {20'd0, pte[43:0]};
            lowm = (w_level == 2'd0) ? 64'd0 : (64'd1 << (w_level * vb)) - 64'd1;
            if ($urandom_range(0, 9) < 8) ppn = ppn & ~lowm;
            pte = (ppn << 10) | {54'd0, pte[9:1], 1'b1};
            if (pte[3:1] == ptw_pkg::RWX_POINTER) pte[1] = 1'b1;
            if ($urandom_range(0, 19) == 0) pte[63:54] = 10'($urandom_range(1, 1023));
            if ($urandom_range(0, 29) == 0) pte[0] = 1'b0;
          end
        end else begin
          op = ptw_pkg::OP_START;
          if (m_wide && (m_root[63:60] == ptw_pkg::MODE_SV39 ||
                         m_root[63:60] == ptw_pkg::MODE_SV48)
              && $urandom_range(0, 9) != 0) begin
            top = (m_root[63:60] == ptw_pkg::MODE_SV39) ? 38 : 47;
            va = va[top] ? (va | ~((64'd1 << top) - 64'd1)) : (va & ((64'd1 << top) - 64'd1));
          end
        end
        send_item(op, va, acc, priv, pte, 1'b0, tr);
      end
    end

    settle();
    $display("Covered %0d items in a directed table and 8 random phases of configuration,",
             items_sent);
    $display("with %0d translations and %0d faults among %0d results.",
             walks_done, faults_seen, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_page_table_walker_core OK");
    end else begin
      $display("tb_page_table_walker_core NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/ptw_pkg.sv
src/ptw_front.sv
src/ptw_queue.sv
src/ptw_back.sv
src/page_table_walker_core.sv
bench/tb_page_table_walker_core.sv
